@@ design/sto_pkg.sv @@
// shared widths and types for the structure tensor orientation core
package sto_pkg;

	// extra fraction bits carried by the square root of the tensor discriminant
	localparam int EXT_BITS = 16;

	localparam int IN_W    = 32;
	localparam int D_W     = IN_W + 1;
	localparam int TRACE_W = IN_W + 1;
	localparam int SQ_W    = 2 * IN_W;
	localparam int H_W     = SQ_W + 2;
	localparam int S_W     = (H_W + 2 * EXT_BITS) / 2;
	localparam int T_W     = TRACE_W + EXT_BITS;

	// vector parts before normalizing
	localparam int A_W     = D_W + EXT_BITS + 2;
	localparam int B_W     = IN_W + EXT_BITS + 1;
	localparam int MAG_W   = A_W - 1;
	localparam int POS_W   = $clog2(MAG_W);

	// the larger normalized part of a nonzero vector lies in [2^NORM_TOP, 2^(NORM_TOP+1))
	localparam int NORM_TOP = 30;
	localparam int NORM_W   = NORM_TOP + 1;
	localparam int L_W      = NORM_W + 1;

	typedef struct packed {
		logic neg;
		logic zero;
	} vec_flags_t;

endpackage

@@ design/sto_sqrt_cell.sv @@
// one digit step of a pipelined restoring square root
module sto_sqrt_cell #(
	parameter int ROOT_W = 32,
	parameter int TAG_W  = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [2*ROOT_W-1:0]   rad,
	input  logic [ROOT_W-1:0]     root,
	input  logic [ROOT_W:0]       rem,
	input  logic [TAG_W-1:0]      tag,
	output logic [2*ROOT_W-1:0]   rad_q,
	output logic [ROOT_W-1:0]     root_q,
	output logic [ROOT_W:0]       rem_q,
	output logic [TAG_W-1:0]      tag_q
);

	logic [ROOT_W+2:0] rem_t;
	logic [ROOT_W+2:0] trial;
	logic [ROOT_W+2:0] diff;
	logic              ge;

	// bring down the next digit pair and try root digit one
	always_comb begin
		rem_t = {rem, rad[2*ROOT_W-1 -: 2]};
		trial = {1'b0, root, 2'b01};
		ge    = (rem_t >= trial);
		diff  = rem_t - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q  <= '0;
			root_q <= '0;
			rem_q  <= '0;
			tag_q  <= '0;
		end else begin
			rad_q  <= rad << 2;
			root_q <= {root[ROOT_W-2:0], ge};
			rem_q  <= ge ? diff[ROOT_W:0] : rem_t[ROOT_W:0];
			tag_q  <= tag;
		end
	end

endmodule

@@ design/sto_div_cell.sv @@
// one quotient bit of a pipelined restoring divider
module sto_div_cell #(
	parameter int W     = 32,
	parameter int N_W   = 16,
	parameter int Q_W   = 16,
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [W-1:0]     rem,
	input  logic [W-1:0]     dvs,
	input  logic [N_W-1:0]   num,
	input  logic [Q_W-1:0]   quo,
	input  logic [TAG_W-1:0] tag,
	output logic [W-1:0]     rem_q,
	output logic [W-1:0]     dvs_q,
	output logic [N_W-1:0]   num_q,
	output logic [Q_W-1:0]   quo_q,
	output logic [TAG_W-1:0] tag_q
);

	logic [W:0] rem2;
	logic [W:0] diff;
	logic       ge;

	always_comb begin
		rem2 = {rem, num[N_W-1]};
		ge   = (rem2 >= {1'b0, dvs});
		diff = rem2 - {1'b0, dvs};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			dvs_q <= '0;
			num_q <= '0;
			quo_q <= '0;
			tag_q <= '0;
		end else begin
			rem_q <= ge ? diff[W-1:0] : rem2[W-1:0];
			dvs_q <= dvs;
			num_q <= num << 1;
			quo_q <= {quo[Q_W-2:0], ge};
			tag_q <= tag;
		end
	end

endmodule

@@ design/sto_vector.sv @@
// unit vector pipeline: normalize, length by square root, divide each part
module sto_vector #(
	parameter int OFB   = 15,
	parameter int TAG_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [sto_pkg::A_W-1:0] a,
	input  logic signed [sto_pkg::B_W-1:0] b,
	input  logic [TAG_W-1:0]              tag,
	output logic [OFB:0]                  unit_x,
	output logic [OFB-1:0]                unit_y,
	output logic [TAG_W-1:0]              tag_q
);

	localparam int MAG_W  = sto_pkg::MAG_W;
	localparam int NORM_W = sto_pkg::NORM_W;
	localparam int L_W    = sto_pkg::L_W;
	localparam int POS_W  = sto_pkg::POS_W;
	localparam int LT_W   = TAG_W + 2 + 2 * NORM_W;
	localparam int NUM_W  = NORM_W + OFB + 1;
	localparam int Q_W    = OFB + 1;

	// magnitudes and signs
	logic [sto_pkg::A_W-1:0] a_neg;
	logic [sto_pkg::B_W-1:0] b_neg;
	logic [MAG_W-1:0]        ma, mb;
	logic [MAG_W-1:0]        ma_s1, mb_s1, ma_s2, mb_s2, ma_s3, mb_s3;
	logic [MAG_W-1:0]        m_s2;
	logic [POS_W-1:0]        pos, pos_s3, sh;
	sto_pkg::vec_flags_t     fl_s1, fl_s2, fl_s3, fl_s4, fl_s5, fl_s6;
	logic [TAG_W-1:0]        tg_s1, tg_s2, tg_s3, tg_s4, tg_s5, tg_s6;
	logic [NORM_W-1:0]       na, nb, na_s4, nb_s4, na_s5, nb_s5, na_s6, nb_s6;
	logic [2*NORM_W-1:0]     sqa_s5, sqb_s5;
	logic [2*L_W-1:0]        lrad_s6;

	always_comb begin
		a_neg = -a;
		b_neg = -b;
		ma    = a[sto_pkg::A_W-1] ? a_neg[MAG_W-1:0] : a[MAG_W-1:0];
		mb    = MAG_W'(b[sto_pkg::B_W-1] ? b_neg : b);
	end

	// leading one of the larger magnitude
	always_comb begin
		pos = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (m_s2[i]) begin
				pos = POS_W'(i);
			end
		end
	end

	// shift both parts so the larger lands on the normalized range
	always_comb begin
		if (pos_s3 >= POS_W'(sto_pkg::NORM_TOP)) begin
			sh = pos_s3 - POS_W'(sto_pkg::NORM_TOP);
			na = NORM_W'(ma_s3 >> sh);
			nb = NORM_W'(mb_s3 >> sh);
		end else begin
			sh = POS_W'(sto_pkg::NORM_TOP) - pos_s3;
			na = NORM_W'(ma_s3 << sh);
			nb = NORM_W'(mb_s3 << sh);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tg_s1 <= '0;
			tg_s2 <= '0;
			tg_s3 <= '0;
			tg_s4 <= '0;
			tg_s5 <= '0;
			tg_s6 <= '0;
		end else begin
			tg_s1 <= tag;
			tg_s2 <= tg_s1;
			tg_s3 <= tg_s2;
			tg_s4 <= tg_s3;
			tg_s5 <= tg_s4;
			tg_s6 <= tg_s5;
		end
	end

	always_ff @(posedge clk) begin
		ma_s1     <= ma;
		mb_s1     <= mb;
		fl_s1.neg <= a[sto_pkg::A_W-1] ^ b[sto_pkg::B_W-1];
		fl_s1.zero <= (a == '0) && (b == '0);
		ma_s2     <= ma_s1;
		mb_s2     <= mb_s1;
		m_s2      <= (ma_s1 > mb_s1) ? ma_s1 : mb_s1;
		fl_s2     <= fl_s1;
		ma_s3     <= ma_s2;
		mb_s3     <= mb_s2;
		pos_s3    <= pos;
		fl_s3     <= fl_s2;
		na_s4     <= na;
		nb_s4     <= nb;
		fl_s4     <= fl_s3;
		sqa_s5    <= na_s4 * na_s4;
		sqb_s5    <= nb_s4 * nb_s4;
		na_s5     <= na_s4;
		nb_s5     <= nb_s4;
		fl_s5     <= fl_s4;
		lrad_s6   <= (2*L_W)'(sqa_s5) + (2*L_W)'(sqb_s5);
		na_s6     <= na_s5;
		nb_s6     <= nb_s5;
		fl_s6     <= fl_s5;
	end

	// vector length, one root bit per cell
	logic [2*L_W-1:0] lrad  [0:L_W];
	logic [L_W-1:0]   lroot [0:L_W];
	logic [L_W:0]     lrem  [0:L_W];
	logic [LT_W-1:0]  ltag  [0:L_W];

	assign lrad[0]  = lrad_s6;
	assign lroot[0] = '0;
	assign lrem[0]  = '0;
	assign ltag[0]  = {tg_s6, fl_s6, na_s6, nb_s6};

	for (genvar i = 0; i < L_W; i++) begin : g_len
		sto_sqrt_cell #(
			.ROOT_W(L_W),
			.TAG_W (LT_W)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.rad   (lrad[i]),
			.root  (lroot[i]),
			.rem   (lrem[i]),
			.tag   (ltag[i]),
			.rad_q (lrad[i+1]),
			.root_q(lroot[i+1]),
			.rem_q (lrem[i+1]),
			.tag_q (ltag[i+1])
		);
	end

	// rounded numerators: part * 2^OFB + len/2
	logic [TAG_W-1:0]    tg_l;
	sto_pkg::vec_flags_t fl_l;
	logic [NORM_W-1:0]   na_l, nb_l;
	logic [NUM_W-1:0]    numx, numy;
	logic [L_W-1:0]      rx_s7, ry_s7, len_s7;
	logic [OFB:0]        nx_s7, ny_s7;
	logic [TAG_W:0]      xt_s7;
	logic                zt_s7;

	always_comb begin
		{tg_l, fl_l, na_l, nb_l} = ltag[L_W];
		numx = NUM_W'({na_l, {OFB{1'b0}}}) + NUM_W'(lroot[L_W] >> 1);
		numy = NUM_W'({nb_l, {OFB{1'b0}}}) + NUM_W'(lroot[L_W] >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xt_s7 <= '0;
			zt_s7 <= 1'b0;
		end else begin
			xt_s7 <= {tg_l, fl_l.neg};
			zt_s7 <= fl_l.zero;
		end
	end

	always_ff @(posedge clk) begin
		len_s7 <= lroot[L_W];
		rx_s7  <= L_W'(numx[NUM_W-1:OFB+1]);
		ry_s7  <= L_W'(numy[NUM_W-1:OFB+1]);
		nx_s7  <= numx[OFB:0];
		ny_s7  <= numy[OFB:0];
	end

	// two dividers side by side, one per part
	logic [L_W-1:0]   xrem [0:Q_W], xdvs [0:Q_W], yrem [0:Q_W], ydvs [0:Q_W];
	logic [OFB:0]     xnum [0:Q_W], xquo [0:Q_W], ynum [0:Q_W], yquo [0:Q_W];
	logic [TAG_W:0]   xtag [0:Q_W];
	logic             ytag [0:Q_W];

	assign xrem[0] = rx_s7;
	assign xdvs[0] = len_s7;
	assign xnum[0] = nx_s7;
	assign xquo[0] = '0;
	assign xtag[0] = xt_s7;
	assign yrem[0] = ry_s7;
	assign ydvs[0] = len_s7;
	assign ynum[0] = ny_s7;
	assign yquo[0] = '0;
	assign ytag[0] = zt_s7;

	for (genvar i = 0; i < Q_W; i++) begin : g_div
		sto_div_cell #(
			.W    (L_W),
			.N_W  (OFB + 1),
			.Q_W  (Q_W),
			.TAG_W(TAG_W + 1)
		) u_xcell (
			.clk   (clk),
			.arst_n(arst_n),
			.rem   (xrem[i]),
			.dvs   (xdvs[i]),
			.num   (xnum[i]),
			.quo   (xquo[i]),
			.tag   (xtag[i]),
			.rem_q (xrem[i+1]),
			.dvs_q (xdvs[i+1]),
			.num_q (xnum[i+1]),
			.quo_q (xquo[i+1]),
			.tag_q (xtag[i+1])
		);
		sto_div_cell #(
			.W    (L_W),
			.N_W  (OFB + 1),
			.Q_W  (Q_W),
			.TAG_W(1)
		) u_ycell (
			.clk   (clk),
			.arst_n(arst_n),
			.rem   (yrem[i]),
			.dvs   (ydvs[i]),
			.num   (ynum[i]),
			.quo   (yquo[i]),
			.tag   (ytag[i]),
			.rem_q (yrem[i+1]),
			.dvs_q (ydvs[i+1]),
			.num_q (ynum[i+1]),
			.quo_q (yquo[i+1]),
			.tag_q (ytag[i+1])
		);
	end

	// saturate a full unit magnitude, apply the sign, clear zero vectors
	logic [OFB-1:0] cx, cy;
	logic [OFB:0]   ux, sx;

	always_comb begin
		cx = xquo[Q_W][OFB] ? {OFB{1'b1}} : xquo[Q_W][OFB-1:0];
		cy = yquo[Q_W][OFB] ? {OFB{1'b1}} : yquo[Q_W][OFB-1:0];
		ux = {1'b0, cx};
		sx = xtag[Q_W][0] ? -ux : ux;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_x <= '0;
			unit_y <= '0;
			tag_q  <= '0;
		end else begin
			unit_x <= ytag[Q_W] ? '0 : sx;
			unit_y <= ytag[Q_W] ? '0 : cy;
			tag_q  <= xtag[Q_W][TAG_W:1];
		end
	end

endmodule

@@ design/structure_tensor_orientation_core.sv @@
// structure tensor coherence and flow/gradient orientation, fully pipelined
// throughput: one word per clock; busy is always low and results never wait
// the pipeline depth is set by the two digit-by-digit square root chains and the dividers
// reset: arst_n clears the valid chain and the cell registers, so no result strobe
// follows reset; the plain datapath stage registers are not reset
module structure_tensor_orientation_core #(
	parameter int OUT_FRAC_BITS = 15
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [31:0]                 tensor_xx,
	input  logic [31:0]                 tensor_yy,
	input  logic signed [31:0]          tensor_xy,
	output logic                        done,
	output logic [OUT_FRAC_BITS:0]      coherence,
	output logic signed [OUT_FRAC_BITS:0] flow_x,
	output logic [OUT_FRAC_BITS-1:0]    flow_y,
	output logic signed [OUT_FRAC_BITS:0] grad_x,
	output logic [OUT_FRAC_BITS-1:0]    grad_y
);

	localparam int OFB     = OUT_FRAC_BITS;
	localparam int IN_W    = sto_pkg::IN_W;
	localparam int D_W     = sto_pkg::D_W;
	localparam int TRACE_W = sto_pkg::TRACE_W;
	localparam int SQ_W    = sto_pkg::SQ_W;
	localparam int H_W     = sto_pkg::H_W;
	localparam int S_W     = sto_pkg::S_W;
	localparam int T_W     = sto_pkg::T_W;
	localparam int EXT     = sto_pkg::EXT_BITS;
	localparam int A_W     = sto_pkg::A_W;
	localparam int B_W     = sto_pkg::B_W;
	localparam int LAT     = 2 * OUT_FRAC_BITS + 96;
	localparam logic [OFB:0] COH_ONE = (OFB+1)'(1) << OFB;

	// the pipeline never stalls
	assign busy = 1'b0;

	// ---------------------------------------------------------------
	// front end: differences, magnitudes, squares, discriminant
	// ---------------------------------------------------------------
	logic                     vld_s1, vld_s2, vld_s3, vld_s4;
	logic [IN_W-1:0]          xx_s1, yy_s1;
	logic signed [IN_W-1:0]   xy_s1, xy_s2, xy_s3, xy_s4;
	logic signed [D_W-1:0]    d_w, d_s2, d_s3, d_s4;
	logic [D_W-1:0]           d_neg;
	logic [IN_W-1:0]          xy_neg;
	logic [IN_W-1:0]          ad, axy, ad_s2, axy_s2;
	logic [TRACE_W-1:0]       tr_s2, tr_s3, tr_s4;
	logic [SQ_W-1:0]          d2_s3, p_s3;
	logic [H_W-1:0]           h_s4;

	always_comb begin
		d_w    = $signed({1'b0, xx_s1}) - $signed({1'b0, yy_s1});
		d_neg  = -d_w;
		xy_neg = -xy_s1;
		ad     = d_w[D_W-1] ? d_neg[IN_W-1:0] : d_w[IN_W-1:0];
		// the most negative cross sum maps onto 2^31, still exact unsigned
		axy    = xy_s1[IN_W-1] ? xy_neg : xy_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		xx_s1  <= tensor_xx;
		yy_s1  <= tensor_yy;
		xy_s1  <= tensor_xy;
		ad_s2  <= ad;
		axy_s2 <= axy;
		d_s2   <= d_w;
		xy_s2  <= xy_s1;
		tr_s2  <= {1'b0, xx_s1} + {1'b0, yy_s1};
		d2_s3  <= ad_s2 * ad_s2;
		p_s3   <= axy_s2 * axy_s2;
		d_s3   <= d_s2;
		xy_s3  <= xy_s2;
		tr_s3  <= tr_s2;
		// h = d^2 + 4 xy^2, exact in 66 bits
		h_s4   <= {2'b00, d2_s3} + {p_s3, 2'b00};
		d_s4   <= d_s3;
		xy_s4  <= xy_s3;
		tr_s4  <= tr_s3;
	end

	// ---------------------------------------------------------------
	// S = floor(sqrt(h * 2^32)), one root bit per cell
	// ---------------------------------------------------------------
	typedef struct packed {
		logic                   vld;
		logic [TRACE_W-1:0]     tr;
		logic signed [D_W-1:0]  d;
		logic signed [IN_W-1:0] xy;
	} sq_tag_t;

	logic [2*S_W-1:0] srad  [0:S_W];
	logic [S_W-1:0]   sroot [0:S_W];
	logic [S_W:0]     srem  [0:S_W];
	sq_tag_t          stag  [0:S_W];

	assign srad[0]  = {h_s4, {(2*EXT){1'b0}}};
	assign sroot[0] = '0;
	assign srem[0]  = '0;
	assign stag[0]  = '{vld: vld_s4, tr: tr_s4, d: d_s4, xy: xy_s4};

	for (genvar i = 0; i < S_W; i++) begin : g_root
		sto_sqrt_cell #(
			.ROOT_W(S_W),
			.TAG_W ($bits(sq_tag_t))
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.rad   (srad[i]),
			.root  (sroot[i]),
			.rem   (srem[i]),
			.tag   (stag[i]),
			.rad_q (srad[i+1]),
			.root_q(sroot[i+1]),
			.rem_q (srem[i+1]),
			.tag_q (stag[i+1])
		);
	end

	// ---------------------------------------------------------------
	// coherence: zero trace and saturation checks, then S / (trace * 2^16)
	// ---------------------------------------------------------------
	typedef struct packed {
		logic                   vld;
		logic                   zero;
		logic                   sat;
		logic signed [D_W-1:0]  d;
		logic signed [IN_W-1:0] xy;
		logic [S_W-1:0]         s;
	} cd_tag_t;

	logic [T_W-1:0] tsc;
	logic [T_W-1:0] t_s5;
	logic [S_W-1:0] s_s5;
	cd_tag_t        ct_s5;

	assign tsc = {stag[S_W].tr, {EXT{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ct_s5 <= '0;
		end else begin
			ct_s5.vld  <= stag[S_W].vld;
			ct_s5.zero <= (stag[S_W].tr == '0);
			ct_s5.sat  <= (T_W'(sroot[S_W]) >= tsc);
			ct_s5.d    <= stag[S_W].d;
			ct_s5.xy   <= stag[S_W].xy;
			ct_s5.s    <= sroot[S_W];
		end
	end

	always_ff @(posedge clk) begin
		t_s5 <= tsc;
		s_s5 <= sroot[S_W];
	end

	logic [T_W-1:0] crem [0:OFB];
	logic [T_W-1:0] cdvs [0:OFB];
	logic           cnum [0:OFB];
	logic [OFB:0]   cquo [0:OFB];
	cd_tag_t        ctag [0:OFB];

	assign crem[0] = T_W'(s_s5);
	assign cdvs[0] = t_s5;
	assign cnum[0] = 1'b0;
	assign cquo[0] = '0;
	assign ctag[0] = ct_s5;

	for (genvar i = 0; i < OFB; i++) begin : g_coh
		sto_div_cell #(
			.W    (T_W),
			.N_W  (1),
			.Q_W  (OFB + 1),
			.TAG_W($bits(cd_tag_t))
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.rem   (crem[i]),
			.dvs   (cdvs[i]),
			.num   (cnum[i]),
			.quo   (cquo[i]),
			.tag   (ctag[i]),
			.rem_q (crem[i+1]),
			.dvs_q (cdvs[i+1]),
			.num_q (cnum[i+1]),
			.quo_q (cquo[i+1]),
			.tag_q (ctag[i+1])
		);
	end

	// ---------------------------------------------------------------
	// vector parts: d*2^16 -/+ S and xy*2^17
	// ---------------------------------------------------------------
	cd_tag_t               ce;
	logic                  vld_s6;
	logic [OFB:0]          coh_s6;
	logic signed [A_W-1:0] dsc, sx, af_s6, ag_s6;
	logic signed [B_W-1:0] b_s6;

	always_comb begin
		ce  = ctag[OFB];
		dsc = $signed({{(A_W-D_W-EXT){ce.d[D_W-1]}}, ce.d, {EXT{1'b0}}});
		sx  = $signed({{(A_W-S_W){1'b0}}, ce.s});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			coh_s6 <= '0;
		end else begin
			vld_s6 <= ce.vld;
			if (ce.zero) begin
				coh_s6 <= '0;
			end else if (ce.sat) begin
				coh_s6 <= COH_ONE;
			end else begin
				coh_s6 <= cquo[OFB];
			end
		end
	end

	always_ff @(posedge clk) begin
		af_s6 <= dsc - sx;
		ag_s6 <= dsc + sx;
		b_s6  <= $signed({ce.xy, {(B_W-IN_W){1'b0}}});
	end

	// ---------------------------------------------------------------
	// two matched unit vector pipelines; flow carries coherence, grad the strobe
	// ---------------------------------------------------------------
	logic [OFB:0]   fx, gx, coh_out;
	logic [OFB-1:0] fy, gy;
	logic           vld_out;

	sto_vector #(
		.OFB  (OFB),
		.TAG_W(OFB + 1)
	) u_flow (
		.clk   (clk),
		.arst_n(arst_n),
		.a     (af_s6),
		.b     (b_s6),
		.tag   (coh_s6),
		.unit_x(fx),
		.unit_y(fy),
		.tag_q (coh_out)
	);

	sto_vector #(
		.OFB  (OFB),
		.TAG_W(1)
	) u_grad (
		.clk   (clk),
		.arst_n(arst_n),
		.a     (ag_s6),
		.b     (b_s6),
		.tag   (vld_s6),
		.unit_x(gx),
		.unit_y(gy),
		.tag_q (vld_out)
	);

	assign done      = vld_out;
	assign coherence = coh_out;
	assign flow_x    = $signed(fx);
	assign flow_y    = fy;
	assign grad_x    = $signed(gx);
	assign grad_y    = gy;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	// an all-zero tensor comes out after the fixed latency as all zeros
	a_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		(start && tensor_xx == '0 && tensor_yy == '0 && tensor_xy == '0) |-> ##LAT
		(done && coherence == '0 && flow_x == '0 && flow_y == '0 &&
		 grad_x == '0 && grad_y == '0))
		else $error("zero tensor word lost or wrong");

	// coherence never goes past one
	a_coh_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (coherence <= COH_ONE))
		else $error("coherence above one");

endmodule
